// ----- rtl/buddy_memory_allocator_defines.svh -----
// Assertion macros for the buddy allocator.
// Used by rtl/buddy_memory_allocator.sv; needs clk_i and rst_ni in scope.
`ifndef BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH
`define BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BMA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define BMA_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define BMA_ASSERT(name, prop)
`define BMA_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ----- rtl/bma_pkg.sv -----
// Shared codes and sequencer states of the buddy allocator.
// No dependencies; imported by rtl/buddy_memory_allocator.sv and by both dv files.
package bma_pkg;

  localparam int OFFW = 13;
  localparam int REQW = 14;
  localparam int STW  = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STW-1:0] STATUS_GRANT = 2'd0;
  localparam logic [STW-1:0] STATUS_FAIL  = 2'd1;
  localparam logic [STW-1:0] STATUS_FREED = 2'd2;

  typedef enum logic [14:0] {
    ST_CLEAR  = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_SCAN   = 15'b000000000000100,
    ST_ARD    = 15'b000000000001000,
    ST_SPLIT  = 15'b000000000010000,
    ST_SPLIT2 = 15'b000000000100000,
    ST_DIV    = 15'b000000001000000,
    ST_FCHK   = 15'b000000010000000,
    ST_FRD    = 15'b000000100000000,
    ST_MCHK   = 15'b000001000000000,
    ST_BRD    = 15'b000010000000000,
    ST_ULCHK  = 15'b000100000000000,
    ST_PUSH   = 15'b001000000000000,
    ST_RES    = 15'b010000000000000,
    ST_SPARE  = 15'b100000000000000
  } state_e;

endpackage

// ----- rtl/buddy_memory_allocator.sv -----
// Binary buddy allocator: sequencer, free-list heads and leaf table memory.
// Depends on bma_pkg and buddy_memory_allocator_defines.svh.
//
//  channel | direction | handshake              | payload
//  in      | to block  | in_valid_i/in_stall_o   | operation_i, request_bytes_i, payload_offset_i
//  out     | from block| out_valid_o/out_stall_i | status_o, granted_offset_o
//
// After reset a clearing pass writes every leaf entry, with in_stall_o high.
// An allocate keeps in_stall_o high through one head probe per order (ST_SCAN), then ST_ARD,
// ST_SPLIT, ST_SPLIT2 and ST_SCAN again for each split.
// A free passes through a reciprocal multiply by LEAF_BYTES, the exactness check and the leaf
// read, then ST_MCHK and ST_BRD per merge plus one ST_ULCHK per list node walked while
// unlinking the buddy, then stops, pushes the block (ST_PUSH) and answers (ST_RES).
// One item at a time; the finished result waits in an output register under out_stall_i.
`include "buddy_memory_allocator_defines.svh"

module buddy_memory_allocator import bma_pkg::*; #(
  parameter int NUM_LEAVES   = 64,
  parameter int LEAF_BYTES   = 128,
  parameter int HEADER_BYTES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [REQW-1:0] request_bytes_i,
  input  logic [OFFW-1:0] payload_offset_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [STW-1:0]  status_o,
  output logic [OFFW-1:0] granted_offset_o
);

  localparam int AW  = $clog2(NUM_LEAVES);
  localparam int LW  = AW + 1;
  localparam int TOP = AW;
  localparam int OW  = $clog2(TOP + 1);
  localparam int TW  = REQW + 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_LEAVES);
  localparam logic [OW-1:0] TOP_ORD = OW'(TOP);
  // Reciprocal of LEAF_BYTES, exact for every offset of OFFW bits.
  localparam int DIV_S = OFFW + $clog2(LEAF_BYTES);
  localparam logic [31:0] DIV_M =
    32'(((64'd1 << DIV_S) + 64'(LEAF_BYTES) - 64'd1) / 64'(LEAF_BYTES));

  typedef struct packed {
    logic          live;
    logic          free;
    logic [OW-1:0] ord;
    logic [LW-1:0] nxt;
  } entry_t;

  state_e state_q, state_d;

  entry_t mem_q [NUM_LEAVES];
  entry_t rd_q;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  logic [LW-1:0] head_q [TOP+1];
  logic [OW-1:0] hidx;
  logic          head_we;
  logic [LW-1:0] head_wd;
  logic [LW-1:0] head_rd;

  logic [OW-1:0]   k_q, k_d, want_q, want_d;
  logic [AW-1:0]   cur_q, cur_d, bud_q, bud_d, walk_q, walk_d, clr_q, clr_d;
  logic [LW-1:0]   bnext_q, bnext_d;
  logic [OFFW-1:0] div_q, div_d;
  logic [OFFW-1:0] quo_q, quo_d;
  logic [STW-1:0]  res_st_q, res_st_d;
  logic [OFFW-1:0] res_off_q, res_off_d;
  logic            out_valid_q;
  logic [STW-1:0]  out_st_q;
  logic [OFFW-1:0] out_off_q;

  logic [TW-1:0]   total;
  logic            fit;
  logic [OW-1:0]   want;
  logic [31:0]     quo_full;
  logic [31:0]     back_full;
  logic [31:0]     off_full;
  logic [AW-1:0]   buddy;

  assign head_rd   = head_q[hidx];
  assign total     = TW'(request_bytes_i) + TW'(HEADER_BYTES);
  assign quo_full  = (32'(div_q) * DIV_M) >> DIV_S;
  assign back_full = 32'(quo_q) * 32'(LEAF_BYTES);
  assign off_full  = 32'(cur_q) * 32'(LEAF_BYTES) + 32'(HEADER_BYTES);
  assign buddy     = cur_q ^ (AW'(1) << k_q);

  // Smallest order whose block covers the header plus payload.
  always_comb begin
    fit  = 1'b0;
    want = '0;
    for (int w = TOP; w >= 0; w--) begin
      if ({17'b0, total} <= (32'(LEAF_BYTES) << w)) begin
        fit  = 1'b1;
        want = OW'(w);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    want_d    = want_q;
    cur_d     = cur_q;
    bud_d     = bud_q;
    walk_d    = walk_q;
    clr_d     = clr_q;
    bnext_d   = bnext_q;
    div_d     = div_q;
    quo_d     = quo_q;
    res_st_d  = res_st_q;
    res_off_d = res_off_q;
    raddr     = cur_q;
    mem_we    = 1'b0;
    waddr     = cur_q;
    wdata     = '{live: 1'b0, free: 1'b0, ord: '0, nxt: NIL};
    hidx      = k_q;
    head_we   = 1'b0;
    head_wd   = NIL;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        if (clr_q == '0) begin
          wdata.free = 1'b1;
          wdata.ord  = TOP_ORD;
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NUM_LEAVES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          res_off_d = '0;
          res_st_d  = STATUS_FAIL;
          if (operation_i == OP_ALLOC) begin
            if (fit) begin
              k_d     = want;
              want_d  = want;
              state_d = ST_SCAN;
            end else begin
              state_d = ST_RES;
            end
          end else if (payload_offset_i < OFFW'(HEADER_BYTES)) begin
            state_d = ST_RES;
          end else begin
            div_d   = payload_offset_i - OFFW'(HEADER_BYTES);
            state_d = ST_DIV;
          end
        end
      end
      ST_SCAN: begin
        if (head_rd != NIL) begin
          cur_d   = head_rd[AW-1:0];
          raddr   = head_rd[AW-1:0];
          state_d = ST_ARD;
        end else if (k_q == TOP_ORD) begin
          state_d = ST_RES;
        end else begin
          k_d = k_q + OW'(1);
        end
      end
      ST_ARD: begin
        head_we = 1'b1;
        head_wd = rd_q.nxt;
        if (k_q == want_q) begin
          mem_we     = 1'b1;
          wdata.live = 1'b1;
          wdata.ord  = want_q;
          res_st_d   = STATUS_GRANT;
          res_off_d  = off_full[OFFW-1:0];
          state_d    = ST_RES;
        end else begin
          k_d     = k_q - OW'(1);
          state_d = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        // Upper half goes on the list first, then the lower half above it.
        mem_we     = 1'b1;
        waddr      = buddy;
        wdata.free = 1'b1;
        wdata.ord  = k_q;
        wdata.nxt  = head_rd;
        state_d    = ST_SPLIT2;
      end
      ST_SPLIT2: begin
        mem_we     = 1'b1;
        wdata.free = 1'b1;
        wdata.ord  = k_q;
        wdata.nxt  = {1'b0, buddy};
        head_we    = 1'b1;
        head_wd    = {1'b0, cur_q};
        state_d    = ST_SCAN;
      end
      ST_DIV: begin
        quo_d   = quo_full[OFFW-1:0];
        state_d = ST_FCHK;
      end
      ST_FCHK: begin
        // The offset must sit exactly on a leaf boundary inside the region.
        if (back_full != 32'(div_q) || {1'b0, quo_q} >= (OFFW + 1)'(NUM_LEAVES)) begin
          state_d = ST_RES;
        end else begin
          cur_d   = quo_q[AW-1:0];
          raddr   = quo_q[AW-1:0];
          state_d = ST_FRD;
        end
      end
      ST_FRD: begin
        if (!rd_q.live) begin
          state_d = ST_RES;
        end else begin
          mem_we    = 1'b1;
          wdata.ord = rd_q.ord;
          wdata.nxt = rd_q.nxt;
          k_d       = rd_q.ord;
          state_d   = ST_MCHK;
        end
      end
      ST_MCHK: begin
        if (k_q == TOP_ORD) begin
          state_d = ST_PUSH;
        end else begin
          bud_d   = buddy;
          raddr   = buddy;
          state_d = ST_BRD;
        end
      end
      ST_BRD: begin
        if (!rd_q.free || rd_q.ord != k_q) begin
          state_d = ST_PUSH;
        end else begin
          mem_we    = 1'b1;
          waddr     = bud_q;
          wdata.ord = k_q;
          bnext_d   = rd_q.nxt;
          if (head_rd == {1'b0, bud_q}) begin
            head_we = 1'b1;
            head_wd = rd_q.nxt;
            if (bud_q < cur_q) begin
              cur_d = bud_q;
            end
            k_d     = k_q + OW'(1);
            state_d = ST_MCHK;
          end else begin
            walk_d  = head_rd[AW-1:0];
            raddr   = head_rd[AW-1:0];
            state_d = ST_ULCHK;
          end
        end
      end
      ST_ULCHK: begin
        // Walk the list until the node in front of the buddy is found.
        if (rd_q.nxt == {1'b0, bud_q}) begin
          mem_we  = 1'b1;
          waddr   = walk_q;
          wdata   = '{live: rd_q.live, free: rd_q.free, ord: rd_q.ord, nxt: bnext_q};
          if (bud_q < cur_q) begin
            cur_d = bud_q;
          end
          k_d     = k_q + OW'(1);
          state_d = ST_MCHK;
        end else begin
          walk_d = rd_q.nxt[AW-1:0];
          raddr  = rd_q.nxt[AW-1:0];
        end
      end
      ST_PUSH: begin
        mem_we     = 1'b1;
        wdata.free = 1'b1;
        wdata.ord  = k_q;
        wdata.nxt  = head_rd;
        head_we    = 1'b1;
        head_wd    = {1'b0, cur_q};
        res_st_d   = STATUS_FREED;
        res_off_d  = '0;
        state_d    = ST_RES;
      end
      ST_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= TOP; i++) begin
        head_q[i] <= (i == TOP) ? LW'(0) : NIL;
      end
    end else if (head_we) begin
      head_q[hidx] <= head_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == ST_RES && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    want_q    <= want_d;
    cur_q     <= cur_d;
    bud_q     <= bud_d;
    walk_q    <= walk_d;
    bnext_q   <= bnext_d;
    div_q     <= div_d;
    quo_q     <= quo_d;
    res_st_q  <= res_st_d;
    res_off_q <= res_off_d;
    if (state_q == ST_RES && (!out_valid_q || !out_stall_i)) begin
      out_st_q  <= res_st_q;
      out_off_q <= res_off_q;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign granted_offset_o = out_off_q;

  `BMA_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != ST_IDLE)
  `BMA_ASSERT(a_offset_only_on_grant, !(out_valid_o && status_o != STATUS_GRANT) || out_off_q == '0)
  `BMA_ASSERT(a_order_in_range, !(state_q == ST_SCAN || state_q == ST_MCHK) || k_q <= TOP_ORD)

endmodule

// ----- dv/buddy_memory_allocator_checker.sv -----
// Scoreboard for the buddy allocator: watches both channels, predicts each result
// with a behavioural model of the allocator and compares. Depends on bma_pkg.
module buddy_memory_allocator_checker import bma_pkg::*; #(
  parameter int NUM_LEAVES   = 64,
  parameter int LEAF_BYTES   = 128,
  parameter int HEADER_BYTES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic            operation_i,
  input  logic [REQW-1:0] request_bytes_i,
  input  logic [OFFW-1:0] payload_offset_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [STW-1:0]  status_i,
  input  logic [OFFW-1:0] granted_offset_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              live_count_o,
  output logic [OFFW-1:0] live_offset_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIL = NUM_LEAVES;
  localparam int TOP = $clog2(NUM_LEAVES);

  typedef struct packed {
    logic [STW-1:0]  status;
    logic [OFFW-1:0] offset;
  } answer_t;

  answer_t answers_q[$];
  int free_head[TOP+1];
  int link_next[NUM_LEAVES];
  int leaf_order[NUM_LEAVES];
  bit leaf_free[NUM_LEAVES];
  bit leaf_live[NUM_LEAVES];
  int live_leaves[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic void add_answer(answer_t a);
    answers_q = {answers_q, a};
  endfunction

  function automatic void push_free(int ord, int leaf);
    link_next[leaf] = free_head[ord];
    free_head[ord] = leaf;
    leaf_order[leaf] = ord;
    leaf_free[leaf] = 1;
  endfunction

  function automatic int pop_free(int ord);
    int leaf;
    leaf = free_head[ord];
    if (leaf >= NIL) return NIL;
    free_head[ord] = link_next[leaf];
    link_next[leaf] = NIL;
    leaf_free[leaf] = 0;
    return leaf;
  endfunction

  function automatic void unlink_free(int ord, int leaf);
    int cur, prev;
    cur = free_head[ord];
    prev = NIL;
    while (cur < NIL) begin
      if (cur == leaf) begin
        if (prev >= NIL) free_head[ord] = link_next[cur];
        else link_next[prev] = link_next[cur];
        link_next[cur] = NIL;
        leaf_free[cur] = 0;
        return;
      end
      prev = cur;
      cur = link_next[cur];
    end
  endfunction

  function automatic void clear_model();
    for (int i = 0; i <= TOP; i++) free_head[i] = NIL;
    for (int i = 0; i < NUM_LEAVES; i++) begin
      link_next[i] = NIL;
      leaf_order[i] = 0;
      leaf_free[i] = 0;
      leaf_live[i] = 0;
    end
    live_leaves.delete();
    push_free(TOP, 0);
  endfunction

  function automatic answer_t allocate_block(int bytes);
    answer_t a;
    int leaves, want, k, b, leaf;
    a = '{status: STATUS_FAIL, offset: '0};
    leaves = (bytes + HEADER_BYTES + LEAF_BYTES - 1) / LEAF_BYTES;
    want = 0;
    while (want <= TOP && (1 << want) < leaves) want++;
    if (want > TOP) return a;
    for (k = want; k <= TOP; k++) if (free_head[k] < NIL) break;
    if (k > TOP) return a;
    while (k > want) begin
      b = pop_free(k);
      k--;
      push_free(k, b ^ (1 << k));
      push_free(k, b);
    end
    leaf = pop_free(want);
    leaf_order[leaf] = want;
    leaf_live[leaf] = 1;
    live_leaves = {live_leaves, leaf};
    a.status = STATUS_GRANT;
    a.offset = OFFW'(leaf * LEAF_BYTES + HEADER_BYTES);
    return a;
  endfunction

  function automatic answer_t release_block(int offset);
    answer_t a;
    int rel, leaf, ord, buddy;
    a = '{status: STATUS_FAIL, offset: '0};
    if (offset < HEADER_BYTES) return a;
    rel = offset - HEADER_BYTES;
    if (rel % LEAF_BYTES != 0) return a;
    leaf = rel / LEAF_BYTES;
    if (leaf >= NIL || !leaf_live[leaf]) return a;
    leaf_live[leaf] = 0;
    foreach (live_leaves[i]) if (live_leaves[i] == leaf) begin
      live_leaves.delete(i);
      break;
    end
    ord = leaf_order[leaf];
    while (ord < TOP) begin
      buddy = leaf ^ (1 << ord);
      if (buddy >= NIL || !leaf_free[buddy] || leaf_order[buddy] != ord) break;
      unlink_free(ord, buddy);
      if (buddy < leaf) leaf = buddy;
      ord++;
    end
    push_free(ord, leaf);
    a.status = STATUS_FREED;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      answers_q.delete();
      clear_model();
      fail_count_o = 0;
      pending_o <= 0;
      live_count_o <= 0;
      live_offset_o <= '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = answers_q.pop_front();
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (granted_offset_i !== want.offset)
            report_mismatch("granted_offset", granted_offset_i, want.offset);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_FREE) add_answer(release_block(payload_offset_i));
        else add_answer(allocate_block(request_bytes_i));
      end
      pending_o <= answers_q.size();
      live_count_o <= live_leaves.size();
      // The middle block of the live list, for the stimulus to free.
      live_offset_o <= live_leaves.size() == 0 ? '0 :
        OFFW'(live_leaves[live_leaves.size() / 2] * LEAF_BYTES + HEADER_BYTES);
    end
  end
endmodule

// ----- dv/buddy_memory_allocator_test.sv -----
// Top of the buddy allocator testbench: clock, reset, stimulus and verdict.
// Depends on bma_pkg, the allocator RTL and dv/buddy_memory_allocator_checker.sv.
module buddy_memory_allocator_test;
  import bma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEAVES = 64;
  localparam int LEAF_BYTES = 128;
  localparam int HEADER_BYTES = 16;
  localparam int RANDOM_BEATS = 1800;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = OP_ALLOC;
  logic [REQW-1:0] request_bytes_i = '0;
  logic [OFFW-1:0] payload_offset_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STW-1:0] status_o;
  logic [OFFW-1:0] granted_offset_o;
  int fail_count, pending, live_count;
  logic [OFFW-1:0] live_offset;
  bit long_hold = 0;
  int idle_cycles = 0;
  int cycle_count = 0;

  buddy_memory_allocator #(
    .NUM_LEAVES(NUM_LEAVES), .LEAF_BYTES(LEAF_BYTES), .HEADER_BYTES(HEADER_BYTES)
  ) i_dut (.*);

  buddy_memory_allocator_checker #(
    .NUM_LEAVES(NUM_LEAVES), .LEAF_BYTES(LEAF_BYTES), .HEADER_BYTES(HEADER_BYTES)
  ) i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i,
    .request_bytes_i, .payload_offset_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .granted_offset_i(granted_offset_o), .fail_count_o(fail_count),
    .pending_o(pending), .live_count_o(live_count), .live_offset_o(live_offset)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver stall pattern: stretches of no stall, random stalls, and one long hold-off.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (long_hold) out_stall_i <= 1'b1;
    else case ((cycle_count / 300) % 3)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic op, input int bytes, input int offset);
    operation_i <= op;
    request_bytes_i <= REQW'(bytes);
    payload_offset_i <= OFFW'(offset);
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // Mostly small requests so the region keeps room; now and then large ones.
      if ($urandom_range(0, 9) == 0) send_beat(OP_ALLOC, $urandom_range(0, 16383), $urandom);
      else send_beat(OP_ALLOC, $urandom_range(0, 600), $urandom);
    end else if (pick < 90 && live_count != 0) begin
      send_beat(OP_FREE, $urandom, live_offset);
    end else if (pick < 95) begin
      send_beat(OP_FREE, $urandom, $urandom_range(0, 8191));
    end else begin
      send_beat(OP_FREE, $urandom, $urandom_range(0, 63) * LEAF_BYTES + HEADER_BYTES);
    end
  endtask

  initial begin
    int hold_cycles;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero size, exact fits, the whole region, too large and bad frees.
    send_beat(OP_ALLOC, 0, 0);
    send_beat(OP_ALLOC, LEAF_BYTES - HEADER_BYTES, 8191);
    send_beat(OP_ALLOC, LEAF_BYTES - HEADER_BYTES + 1, 0);
    send_beat(OP_FREE, 0, HEADER_BYTES);
    send_beat(OP_FREE, 0, HEADER_BYTES);
    send_beat(OP_FREE, 16383, 0);
    send_beat(OP_FREE, 0, HEADER_BYTES + 1);
    send_beat(OP_FREE, 0, 8191);
    send_beat(OP_FREE, 0, LEAF_BYTES + HEADER_BYTES);
    send_beat(OP_FREE, 0, 2 * LEAF_BYTES + HEADER_BYTES);
    send_beat(OP_ALLOC, NUM_LEAVES * LEAF_BYTES - HEADER_BYTES, 0);
    send_beat(OP_ALLOC, 1, 0);
    send_beat(OP_FREE, 0, HEADER_BYTES);
    send_beat(OP_ALLOC, NUM_LEAVES * LEAF_BYTES - HEADER_BYTES + 1, 0);
    send_beat(OP_ALLOC, 8192, 0);
    send_beat(OP_ALLOC, 16383, 0);
    for (int i = 0; i < 6; i++) send_beat(OP_ALLOC, 10 * LEAF_BYTES, 0);
    drain_results();

    // The sender keeps offering while the receiver holds off, so the block backs up.
    long_hold <= 1'b1;
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        long_hold <= 1'b0;
      end
      for (int i = 0; i < 8; i++) random_beat();
    join

    for (int n = 0; n < RANDOM_BEATS; ) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        random_beat();
        n++;
      end
      if (n % 500 < 20) drain_results();
      else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 30));
    end

    drain_results();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
